### sv/fur16_pkg.sv
// Shared types and constants of the framed serial receiver.
package fur16_pkg;

  localparam int unsigned FRAME_STORE_BYTES = 256;
  localparam int unsigned POS_W = 9;
  localparam int unsigned LIM_W = 10;
  localparam logic [LIM_W-1:0] FRAME_STORE_LIM = LIM_W'(FRAME_STORE_BYTES);

  typedef enum logic [2:0] {
    ST_DISCARD = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_DONE    = 3'd2,
    ST_LEN_BAD = 3'd3,
    ST_SUM_BAD = 3'd4,
    ST_END_BAD = 3'd5
  } status_t;

  typedef enum logic {
    CFG_START_MARKER = 1'b0,
    CFG_END_MARKER   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
  } cfg_t;

  typedef struct packed {
    status_t    status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_id;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;
  } result_t;

endpackage

### sv/fur16_if.sv
// Request channels of the framed serial receiver: received bytes in, results out.
interface fur16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fur16_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_id;
  logic [7:0] frame_cmd;
  logic [7:0] frame_len;

  modport source (
    output valid, output status, output payload_valid, output payload_byte,
    output payload_index, output frame_id, output frame_cmd, output frame_len,
    input ready
  );
  modport sink (
    input valid, input status, input payload_valid, input payload_byte,
    input payload_index, input frame_id, input frame_cmd, input frame_len,
    output ready
  );
endinterface

### sv/fur16_cfg_regs.sv
// Start and end marker registers written through the plain write port.
module fur16_cfg_regs
  import fur16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= 8'd1;
      cfg.end_marker   <= 8'd4;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_MARKER: cfg.start_marker <= cfg_data;
        CFG_END_MARKER:   cfg.end_marker   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/fur16_in_stage.sv
// Input register: holds one received byte until the parser takes it.
module fur16_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= in_byte;
    end
  end

endmodule

### sv/fur16_parser.sv
// Frame parser: position, header fields and running checksum, one byte a step.
module fur16_parser
  import fur16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       held_id, held_id_next;
  logic [7:0]       held_cmd, held_cmd_next;
  logic [7:0]       held_len, held_len_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       sum_high_byte, sum_high_byte_next;

  logic [LIM_W-1:0] pos_ext, len_ext, pay_off;
  logic [15:0]      sum_plus;

  assign pos_ext  = LIM_W'(byte_position);
  assign len_ext  = LIM_W'(held_len);
  assign pay_off  = pos_ext - LIM_W'(4);
  assign sum_plus = running_sum + 16'(rx_byte);

  always_comb begin
    byte_position_next   = byte_position + POS_W'(1);
    held_id_next         = held_id;
    held_cmd_next        = held_cmd;
    held_len_next        = held_len;
    running_sum_next     = running_sum;
    sum_high_byte_next   = sum_high_byte;
    result.status        = ST_ACCEPT;
    result.payload_valid = 1'b0;
    result.payload_byte  = 8'd0;
    result.payload_index = 8'd0;

    if (byte_position == POS_W'(0)) begin
      if (rx_byte == cfg.start_marker) begin
        running_sum_next = 16'd0;
      end else begin
        result.status      = ST_DISCARD;
        byte_position_next = '0;
      end
    end else if (byte_position == POS_W'(1)) begin
      held_id_next     = rx_byte;
      running_sum_next = sum_plus;
    end else if (byte_position == POS_W'(2)) begin
      held_cmd_next    = rx_byte;
      running_sum_next = sum_plus;
    end else if (byte_position == POS_W'(3)) begin
      held_len_next    = rx_byte;
      running_sum_next = sum_plus;
    end else if (LIM_W'(7) + len_ext > FRAME_STORE_LIM) begin
      result.status      = ST_LEN_BAD;
      byte_position_next = '0;
    end else if (pos_ext < LIM_W'(4) + len_ext) begin
      running_sum_next     = sum_plus;
      result.payload_valid = 1'b1;
      result.payload_byte  = rx_byte;
      result.payload_index = pay_off[7:0];
    end else if (pos_ext == LIM_W'(4) + len_ext) begin
      sum_high_byte_next = rx_byte;
    end else if (pos_ext == LIM_W'(5) + len_ext) begin
      if ({sum_high_byte, rx_byte} != running_sum) begin
        result.status      = ST_SUM_BAD;
        byte_position_next = '0;
      end
    end else begin
      // end byte, or a position past the frame that counts as a bad end
      if (pos_ext == LIM_W'(6) + len_ext && rx_byte == cfg.end_marker) begin
        result.status = ST_DONE;
      end else begin
        result.status = ST_END_BAD;
      end
      byte_position_next = '0;
    end

    result.frame_id  = held_id_next;
    result.frame_cmd = held_cmd_next;
    result.frame_len = held_len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      held_id       <= 8'd0;
      held_cmd      <= 8'd0;
      held_len      <= 8'd0;
      running_sum   <= 16'd0;
      sum_high_byte <= 8'd0;
    end else if (step) begin
      byte_position <= byte_position_next;
      held_id       <= held_id_next;
      held_cmd      <= held_cmd_next;
      held_len      <= held_len_next;
      running_sum   <= running_sum_next;
      sum_high_byte <= sum_high_byte_next;
    end
  end

endmodule

### sv/fur16_out_stage.sv
// Result register: holds one status request until the sink takes it.
module fur16_out_stage
  import fur16_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  output logic    res_ready,
  input  result_t res_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

### sv/framed_uart_receiver_sum16_unit.sv
// Framed serial receiver with 16-bit additive checksum: one status request per byte.
// A status request passes from the input register through the parser into the output
// register; the parser step waits while the output register is full.
// Throughput: one byte per cycle unless the sink stalls; set by the one-step parser.
// Reset (synchronous, active high) clears position, header fields, checksum and
// both pipeline registers, and returns the markers to 1 (start) and 4 (end).
module framed_uart_receiver_sum16_unit
  import fur16_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic        cfg_index,
  input logic [7:0]  cfg_data,
  fur16_in_if.sink   in_ch,
  fur16_out_if.source out_ch
);

  cfg_t       cfg;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       res_ready;
  logic       step;
  result_t    step_result;
  result_t    out_data;

  // Marker registers: user writes only while no request is in flight; not enforced.
  fur16_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Hold the received byte; refill in the same cycle the parser drains it.
  fur16_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.rx_byte),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  // Advance the parser only when its result has a place in the output register,
  // so frame state moves exactly once per delivered status.
  assign step = held_valid && res_ready;

  fur16_parser u_parse (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .rx_byte (held_byte),
    .result  (step_result)
  );

  // Output register parts the parser from the sink. A waiting result holds the
  // parser; the input register may still take one byte, then holds it and stalls
  // the input until the sink drains the output register.
  fur16_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (held_valid),
    .res_ready (res_ready),
    .res_data  (step_result),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.status        = out_data.status;
  assign out_ch.payload_valid = out_data.payload_valid;
  assign out_ch.payload_byte  = out_data.payload_byte;
  assign out_ch.payload_index = out_data.payload_index;
  assign out_ch.frame_id      = out_data.frame_id;
  assign out_ch.frame_cmd     = out_data.frame_cmd;
  assign out_ch.frame_len     = out_data.frame_len;

endmodule

### dv/framed_uart_receiver_sum16_unit_test.sv
// Self-checking testbench of the framed serial receiver with 16-bit additive checksum.
`timescale 1ns / 100ps

module framed_uart_receiver_sum16_unit_test;
  import fur16_pkg::*;

  // Markers that the block comes out of reset with.
  localparam logic [7:0] RESET_START = 8'h01;
  localparam logic [7:0] RESET_END   = 8'h04;
  // Ceiling on the run; far above the slowest correct run with both sides idling.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  // Largest payload that still fits the frame store.
  localparam int unsigned MAX_LEN = FRAME_STORE_BYTES - 7;

  // Ways a generated frame can be spoilt.
  typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_END,
    FLAW_CUT
  } flaw_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [7:0] cfg_data;

  fur16_in_if  in_ch ();
  fur16_out_if out_ch ();

  framed_uart_receiver_sum16_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Bytes waiting to be offered, and results still owed by the block.
  logic [7:0]  byte_backlog[$];
  result_t     awaited_results[$];

  int unsigned sender_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned fail_count;
  int unsigned cycle_count;

  // Mirror of the marker registers and of the parser state.
  cfg_t        marker_cfg;
  logic [8:0]  frame_pos;
  logic [7:0]  hdr_id;
  logic [7:0]  hdr_cmd;
  logic [7:0]  hdr_len;
  logic [15:0] sum_acc;
  logic [7:0]  sum_hi;

  always #10 clk = ~clk;

  // Advance the parser mirror by one received byte and return the status it yields.
  function automatic result_t parse_rx_byte(logic [7:0] b);
    result_t     r;
    int unsigned pos;
    int unsigned len;
    int unsigned nxt;
    pos = frame_pos;
    len = hdr_len;
    nxt = pos + 1;
    r = '0;
    r.status = ST_ACCEPT;
    if (pos == 0) begin
      // Only the start marker opens a frame; it clears the sum but not the header.
      if (b == marker_cfg.start_marker) begin
        sum_acc = '0;
      end else begin
        r.status = ST_DISCARD;
        nxt = 0;
      end
    end else if (pos == 1) begin
      hdr_id = b;
      sum_acc = sum_acc + 16'(b);
    end else if (pos == 2) begin
      hdr_cmd = b;
      sum_acc = sum_acc + 16'(b);
    end else if (pos == 3) begin
      hdr_len = b;
      sum_acc = sum_acc + 16'(b);
    end else if (7 + len > FRAME_STORE_BYTES) begin
      // Oversized length is caught on the byte after the length field.
      r.status = ST_LEN_BAD;
      nxt = 0;
    end else if (pos < 4 + len) begin
      sum_acc = sum_acc + 16'(b);
      r.payload_valid = 1'b1;
      r.payload_byte = b;
      r.payload_index = 8'(pos - 4);
    end else if (pos == 4 + len) begin
      sum_hi = b;
    end else if (pos == 5 + len) begin
      if ({sum_hi, b} != sum_acc) begin
        r.status = ST_SUM_BAD;
        nxt = 0;
      end
    end else begin
      // Closing byte: complete only on the end marker; anything else drops the frame.
      r.status = (pos == 6 + len && b == marker_cfg.end_marker) ? ST_DONE : ST_END_BAD;
      nxt = 0;
    end
    frame_pos = 9'(nxt);
    r.frame_id = hdr_id;
    r.frame_cmd = hdr_cmd;
    r.frame_len = hdr_len;
    return r;
  endfunction

  // Queue one frame under the current markers, spoilt as asked.
  task automatic queue_frame(logic [7:0] id, logic [7:0] cmd, logic [7:0] len, flaw_t flaw);
    logic [15:0] sum;
    logic [7:0]  b;
    int          cut_at;
    sum = 16'(id) + 16'(cmd) + 16'(len);
    byte_backlog.push_back(marker_cfg.start_marker);
    byte_backlog.push_back(id);
    byte_backlog.push_back(cmd);
    byte_backlog.push_back(len);
    if (7 + int'(len) > FRAME_STORE_BYTES) begin
      // One more byte is enough to trip the length check.
      byte_backlog.push_back(8'($urandom_range(255)));
      return;
    end
    cut_at = (flaw == FLAW_CUT) ? int'($urandom_range(int'(len) + 2)) : -1;
    for (int i = 0; i < int'(len); i++) begin
      if (i == cut_at) return;
      b = 8'($urandom_range(255));
      sum = sum + 16'(b);
      byte_backlog.push_back(b);
    end
    if (flaw == FLAW_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
    if (cut_at == int'(len)) return;
    byte_backlog.push_back(sum[15:8]);
    if (cut_at == int'(len) + 1) return;
    byte_backlog.push_back(sum[7:0]);
    if (cut_at == int'(len) + 2) return;
    if (flaw == FLAW_END)
      byte_backlog.push_back(marker_cfg.end_marker ^ 8'($urandom_range(1, 255)));
    else
      byte_backlog.push_back(marker_cfg.end_marker);
  endtask

  // Mostly sound frames with random content; the rest is spoilt frames and line noise.
  task automatic queue_random_traffic();
    int unsigned pick;
    flaw_t       flaw;
    logic [7:0]  len;
    pick = $urandom_range(99);
    if (pick >= 93) begin
      repeat ($urandom_range(1, 4)) byte_backlog.push_back(8'($urandom_range(255)));
      return;
    end
    if (pick < 70)      flaw = FLAW_NONE;
    else if (pick < 78) flaw = FLAW_SUM;
    else if (pick < 86) flaw = FLAW_END;
    else                flaw = FLAW_CUT;
    if ($urandom_range(99) < 4) len = 8'($urandom_range(MAX_LEN + 1, 255));
    else                        len = 8'($urandom_range(12));
    queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, flaw);
  endtask

  // Hold until every byte has gone in and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_ch.valid || awaited_results.size() != 0);
  endtask

  task automatic write_marker(cfg_index_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_START_MARKER) marker_cfg.start_marker = value;
    else                         marker_cfg.end_marker = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: predict each accepted byte, then offer the next one unless idling.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.rx_byte <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) awaited_results.push_back(parse_rx_byte(in_ch.rx_byte));
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.rx_byte <= byte_backlog.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest one owed, stall at random.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with none awaited: status %0d", out_ch.status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 8'(want.status), 8'(out_ch.status));
          check_field("payload_valid", 8'(want.payload_valid), 8'(out_ch.payload_valid));
          check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
          check_field("payload_index", want.payload_index, out_ch.payload_index);
          check_field("frame_id", want.frame_id, out_ch.frame_id);
          check_field("frame_cmd", want.frame_cmd, out_ch.frame_cmd);
          check_field("frame_len", want.frame_len, out_ch.frame_len);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] start_sel;
    logic [7:0] end_sel;
    int unsigned queued_floor;
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_START_MARKER;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    sender_idle_pct = 0;
    sink_stall_pct = 0;
    fail_count = 0;
    cycle_count = 0;
    marker_cfg.start_marker = RESET_START;
    marker_cfg.end_marker = RESET_END;
    frame_pos = '0;
    hdr_id = '0;
    hdr_cmd = '0;
    hdr_len = '0;
    sum_acc = '0;
    sum_hi = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset markers.
    byte_backlog = {
      // line noise, discarded
      8'h00,
      // all-ones and all-zeros header and payload, checksum 0x0200, clean close
      RESET_START, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h02, 8'h00, RESET_END,
      // empty payload, checksum low byte wrong
      RESET_START, 8'h10, 8'h20, 8'h00, 8'h00, 8'h31,
      // length too large for the frame store
      RESET_START, 8'h00, 8'h00, 8'hFA, 8'h77,
      // good checksum, wrong closing byte
      RESET_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05
    };

    // Random phases, each under its own markers and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          start_sel = 8'h00;
          end_sel = 8'hFF;
          sender_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          start_sel = 8'hFF;
          end_sel = 8'h00;
          sender_idle_pct = 55;
          sink_stall_pct = 0;
        end
        2: begin
          start_sel = 8'($urandom_range(255));
          end_sel = 8'($urandom_range(255));
          sender_idle_pct = 0;
          sink_stall_pct = 55;
        end
        default: begin
          // start and end marker share one value
          start_sel = 8'($urandom_range(255));
          end_sel = start_sel;
          sender_idle_pct = 21;
          sink_stall_pct = 21;
        end
      endcase
      write_marker(CFG_START_MARKER, start_sel);
      write_marker(CFG_END_MARKER, end_sel);
      for (int half = 0; half < 2; half++) begin
        if (ph == 2 && half == 0) begin
          // largest payload that fits, then the first length that does not
          queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 8'(MAX_LEN), FLAW_NONE);
          queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 8'(MAX_LEN + 1),
                      FLAW_NONE);
        end
        queued_floor = byte_backlog.size() + 25;
        while (byte_backlog.size() < queued_floor) queue_random_traffic();
        // Hold further requests until every result of this batch is back.
        wait_drained();
      end
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
